// ===== sv/multi_tap_feedback_delay_bank_top_assert.svh =====
`ifndef MULTI_TAP_FEEDBACK_DELAY_BANK_TOP_ASSERT_SVH
`define MULTI_TAP_FEEDBACK_DELAY_BANK_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MTFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define MTFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/mtfd_pkg.sv =====
package mtfd_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_BITS   = 15;
  localparam int CFG_W       = 20;
  localparam int CFG_IDX_W   = 4;

  localparam int MAIN_AW  = 20;
  localparam int SHORT_AW = 18;
  localparam int HIGH_AW  = 21;
  localparam int LOW_AW   = 21;
  localparam int CLR_AW   = 21;

  localparam int SHORT_GAP = 44100;
  localparam int HIGH_LAG  = 837881;
  localparam int LOW_LAG   = 1322970;

  localparam logic [HIGH_AW-1:0] HIGH_RP_RESET =
    HIGH_AW'(((1 << HIGH_AW) - (HIGH_LAG % (1 << HIGH_AW))) % (1 << HIGH_AW));
  localparam logic [LOW_AW-1:0] LOW_RP_RESET =
    LOW_AW'(((1 << LOW_AW) - (LOW_LAG % (1 << LOW_AW))) % (1 << LOW_AW));
  localparam logic [SHORT_AW-1:0] SHORT_OFS = SHORT_AW'(SHORT_GAP % (1 << SHORT_AW));

  localparam int PROD_W = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int SUM_W  = SAMPLE_BITS + 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAIN_FB   = 4'd0,
    REG_SHORT_FB  = 4'd1,
    REG_PITCH_FB  = 4'd2,
    REG_MAIN_DLY  = 4'd3,
    REG_G1_START  = 4'd4,
    REG_G1_LEN    = 4'd5,
    REG_G2_START  = 4'd6,
    REG_G2_LEN    = 4'd7
  } reg_idx_t;

  localparam logic [GAIN_BITS-1:0] MAIN_FB_RESET  = 15'd16384;
  localparam logic [GAIN_BITS-1:0] SHORT_FB_RESET = 15'd13107;
  localparam logic [GAIN_BITS-1:0] PITCH_FB_RESET = 15'd26214;
  localparam logic [CFG_W-1:0]     MAIN_DLY_RESET = 20'd330750;
  localparam logic [CFG_W-1:0]     G_START_RESET  = 20'd0;
  localparam logic [CFG_W-1:0]     G_LEN_RESET    = 20'd10000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD1, ST_MUL_M1, ST_WR_M1, ST_RD_M2, ST_MUL_M2, ST_WR_M2, ST_RD_M3,
    ST_MUL_S1, ST_WR_S1, ST_RD_S2, ST_MUL_S2, ST_WR_S2, ST_RD_S3, ST_MUL_L,
    ST_WR_L1, ST_WR_L2, ST_RD_L, ST_MUL_H, ST_WR_H, ST_RD_H, ST_DONE
  } state_t;

  // dry + rounded feedback term, clipped to the sample range
  function automatic sample_t fb_sum(input sample_t dry, input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W-1:0] rnd;
    logic signed [SUM_W-1:0]  s;
    rnd = prod + PROD_W'(16384);
    s = SUM_W'(dry) + SUM_W'(rnd >>> 15);
    if (s > SUM_W'(2 ** (SAMPLE_BITS - 1) - 1))
      return sample_t'(2 ** (SAMPLE_BITS - 1) - 1);
    else if (s < -SUM_W'(2 ** (SAMPLE_BITS - 1)))
      return sample_t'(-(2 ** (SAMPLE_BITS - 1)));
    else
      return s[SAMPLE_BITS-1:0];
  endfunction

endpackage

// ===== sv/multi_tap_feedback_delay_bank_top.sv =====
// Multi-tap feedback delay bank. Each input word (one signed sample) yields one output word
// of seven taps: mix, short, chained, octave-down, octave-up and two grain loops. A new item
// starts only after the previous one has left the done state: the idle state loads the sample,
// twenty steps walk one shared 24x16 multiplier and four single-port memories (main 1M,
// short 256K, octave-up 2M, octave-down 2M entries) through their read, scale and write-back
// steps, and the done state hands the word to the output register, waiting while the output
// stalls. One further input word is buffered while an item runs, and a finished word waits
// in the output register. After reset a clearing pass steps through every address and zeroes
// all memories; input stays stalled until it ends, while configuration writes are taken at
// any time (cfg_ready is always high).
module multi_tap_feedback_delay_bank_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [mtfd_pkg::SAMPLE_BITS-1:0] sample_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [mtfd_pkg::SAMPLE_BITS-1:0] mix_out,
  output logic signed [mtfd_pkg::SAMPLE_BITS-1:0] short_out,
  output logic signed [mtfd_pkg::SAMPLE_BITS-1:0] chained_out,
  output logic signed [mtfd_pkg::SAMPLE_BITS-1:0] low_out,
  output logic signed [mtfd_pkg::SAMPLE_BITS-1:0] high_out,
  output logic signed [mtfd_pkg::SAMPLE_BITS-1:0] grain_one_out,
  output logic signed [mtfd_pkg::SAMPLE_BITS-1:0] grain_two_out,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mtfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mtfd_pkg::CFG_W-1:0]         cfg_data
);
  import mtfd_pkg::*;

  `include "multi_tap_feedback_delay_bank_top_assert.svh"

  // configuration
  logic [GAIN_BITS-1:0] main_fb, short_fb, pitch_fb;
  logic [CFG_W-1:0]     main_dly, g1_start, g1_len, g2_start, g2_len;

  // control
  state_t state, state_next;
  logic   clearing;
  logic [CLR_AW-1:0] clr_cnt;
  logic   in_full;
  sample_t in_buf, x;
  logic   done_go;

  // pointers
  logic [MAIN_AW-1:0]  main_wp;
  logic [SHORT_AW-1:0] short_wp;
  logic [HIGH_AW-1:0]  high_wp, high_rp;
  logic [LOW_AW-1:0]   low_wp, low_rp;
  logic                low_phase;
  sample_t             low_hold;
  logic [CFG_W-1:0]    g1_pos, g2_pos, g1_next, g2_next;

  // datapath
  sample_t tap1, tap2, r_short, r_chained, r_low, r_g1, r_g2;
  logic signed [PROD_W-1:0] prod;
  sample_t mul_a;
  logic [GAIN_BITS-1:0] mul_g;
  sample_t sum_dry, sum_val;

  // memories
  sample_t main_mem  [2**MAIN_AW];
  sample_t short_mem [2**SHORT_AW];
  sample_t high_mem  [2**HIGH_AW];
  sample_t low_mem   [2**LOW_AW];
  sample_t main_q, short_q, high_q, low_q;

  logic m_we, m_re, s_we, s_re, h_we, h_re, l_we, l_re;
  logic [MAIN_AW-1:0]  m_wa, m_ra, main_rp;
  logic [SHORT_AW-1:0] s_wa, s_ra, short_rp;
  logic [HIGH_AW-1:0]  h_wa, h_ra;
  logic [LOW_AW-1:0]   l_wa, l_ra;
  sample_t m_wd, s_wd, h_wd, l_wd;

  assign cfg_ready = 1'b1;
  assign in_stall  = clearing || in_full;
  assign done_go   = (state == ST_DONE) && (!out_valid || !out_stall);

  assign main_rp  = main_wp - main_dly[MAIN_AW-1:0];
  assign short_rp = short_wp - SHORT_OFS;

  assign g1_next = ((21'(g1_pos) >= 21'(g1_start) + 21'(g1_len)) || (&g1_pos))
                   ? g1_start : g1_pos + 1'b1;
  assign g2_next = ((21'(g2_pos) >= 21'(g2_start) + 21'(g2_len)) || (&g2_pos))
                   ? g2_start : g2_pos + 1'b1;

  assign sum_val = fb_sum(sum_dry, prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      main_fb  <= MAIN_FB_RESET;
      short_fb <= SHORT_FB_RESET;
      pitch_fb <= PITCH_FB_RESET;
      main_dly <= MAIN_DLY_RESET;
      g1_start <= G_START_RESET;
      g1_len   <= G_LEN_RESET;
      g2_start <= G_START_RESET;
      g2_len   <= G_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAIN_FB:  main_fb  <= cfg_data[GAIN_BITS-1:0];
        REG_SHORT_FB: short_fb <= cfg_data[GAIN_BITS-1:0];
        REG_PITCH_FB: pitch_fb <= cfg_data[GAIN_BITS-1:0];
        REG_MAIN_DLY: main_dly <= cfg_data;
        REG_G1_START: g1_start <= cfg_data;
        REG_G1_LEN:   g1_len   <= cfg_data;
        REG_G2_START: g2_start <= cfg_data;
        REG_G2_LEN:   g2_len   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (&clr_cnt) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
      in_buf  <= sample_in;
    end else if (state == ST_IDLE && in_full) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_full && !clearing) state_next = ST_RD1;
      ST_RD1:    state_next = ST_MUL_M1;
      ST_MUL_M1: state_next = ST_WR_M1;
      ST_WR_M1:  state_next = ST_RD_M2;
      ST_RD_M2:  state_next = ST_MUL_M2;
      ST_MUL_M2: state_next = ST_WR_M2;
      ST_WR_M2:  state_next = ST_RD_M3;
      ST_RD_M3:  state_next = ST_MUL_S1;
      ST_MUL_S1: state_next = ST_WR_S1;
      ST_WR_S1:  state_next = ST_RD_S2;
      ST_RD_S2:  state_next = ST_MUL_S2;
      ST_MUL_S2: state_next = ST_WR_S2;
      ST_WR_S2:  state_next = ST_RD_S3;
      ST_RD_S3:  state_next = ST_MUL_L;
      ST_MUL_L:  state_next = ST_WR_L1;
      ST_WR_L1:  state_next = ST_WR_L2;
      ST_WR_L2:  state_next = ST_RD_L;
      ST_RD_L:   state_next = ST_MUL_H;
      ST_MUL_H:  state_next = ST_WR_H;
      ST_WR_H:   state_next = ST_RD_H;
      ST_RD_H:   state_next = ST_DONE;
      ST_DONE:   if (done_go) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory controls and multiplier operands per step
  always_comb begin
    m_we = 1'b0; m_re = 1'b0; m_wa = main_wp; m_ra = main_rp; m_wd = sum_val;
    s_we = 1'b0; s_re = 1'b0; s_wa = short_wp; s_ra = short_rp; s_wd = sum_val;
    h_we = 1'b0; h_re = 1'b0; h_wa = high_wp; h_ra = high_rp; h_wd = sum_val;
    l_we = 1'b0; l_re = 1'b0; l_wa = low_wp; l_ra = low_rp; l_wd = sum_val;
    mul_a = main_q; mul_g = main_fb; sum_dry = x;
    unique case (state)
      ST_RD1: begin
        m_re = 1'b1; s_re = 1'b1; h_re = 1'b1; l_re = 1'b1;
      end
      ST_WR_M1:  m_we = 1'b1;
      ST_RD_M2: begin
        m_re = 1'b1; m_ra = main_rp + 1'b1;
      end
      ST_WR_M2: begin
        m_we = 1'b1; m_wa = main_wp + 1'b1;
      end
      ST_RD_M3: begin
        m_re = 1'b1; m_ra = main_rp + 2'd2;
      end
      ST_MUL_S1: begin
        mul_a = short_q; mul_g = short_fb;
      end
      ST_WR_S1:  s_we = 1'b1;
      ST_RD_S2: begin
        s_re = 1'b1; s_ra = short_rp + 1'b1;
      end
      ST_MUL_S2: begin
        mul_a = short_q; mul_g = short_fb;
      end
      ST_WR_S2: begin
        s_we = 1'b1; s_wa = short_wp + 1'b1; sum_dry = tap2;
      end
      ST_RD_S3: begin
        s_re = 1'b1; s_ra = short_rp + 2'd2;
        m_re = 1'b1; m_ra = g1_next[MAIN_AW-1:0];
      end
      ST_MUL_L: begin
        m_re = 1'b1; m_ra = g2_next[MAIN_AW-1:0];
        mul_a = low_q; mul_g = pitch_fb;
      end
      ST_WR_L1: begin
        l_we = 1'b1; l_wd = low_phase ? sum_val : low_hold;
      end
      ST_WR_L2: begin
        l_we = !low_phase; l_wa = low_wp + 1'b1; l_wd = low_hold;
      end
      ST_RD_L: begin
        l_re = 1'b1; l_ra = low_rp + 1'b1;
      end
      ST_MUL_H: begin
        mul_a = high_q; mul_g = pitch_fb;
      end
      ST_WR_H:   h_we = 1'b1;
      ST_RD_H: begin
        h_re = 1'b1; h_ra = high_rp + 2'd2;
      end
      default: ;
    endcase
    // clearing pass owns the write ports
    if (clearing) begin
      m_we = 1'b1; m_wa = clr_cnt[MAIN_AW-1:0]; m_wd = '0;
      s_we = 1'b1; s_wa = clr_cnt[SHORT_AW-1:0]; s_wd = '0;
      h_we = 1'b1; h_wa = clr_cnt[HIGH_AW-1:0]; h_wd = '0;
      l_we = 1'b1; l_wa = clr_cnt[LOW_AW-1:0]; l_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (m_we) main_mem[m_wa] <= m_wd;
    if (m_re) main_q <= main_mem[m_ra];
  end

  always_ff @(posedge clk) begin
    if (s_we) short_mem[s_wa] <= s_wd;
    if (s_re) short_q <= short_mem[s_ra];
  end

  always_ff @(posedge clk) begin
    if (h_we) high_mem[h_wa] <= h_wd;
    if (h_re) high_q <= high_mem[h_ra];
  end

  always_ff @(posedge clk) begin
    if (l_we) low_mem[l_wa] <= l_wd;
    if (l_re) low_q <= low_mem[l_ra];
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * $signed({1'b0, mul_g});
    if (state == ST_IDLE)   x <= in_buf;
    if (state == ST_MUL_M2) tap1 <= main_q;
    if (state == ST_MUL_S1) tap2 <= main_q;
    if (state == ST_MUL_S2) r_short <= short_q;
    if (state == ST_MUL_L) begin
      r_chained <= short_q;
      r_g1      <= main_q;
    end
    if (state == ST_WR_L1) r_g2 <= main_q;
    if (state == ST_MUL_H) r_low <= low_q;
  end

  // pointers and loop positions
  always_ff @(posedge clk) begin
    if (rst) begin
      main_wp   <= '0;
      short_wp  <= '0;
      high_wp   <= '0;
      high_rp   <= HIGH_RP_RESET;
      low_wp    <= '0;
      low_rp    <= LOW_RP_RESET;
      low_hold  <= '0;
      low_phase <= 1'b1;
      g1_pos    <= G_START_RESET;
      g2_pos    <= G_START_RESET;
    end else begin
      if (state == ST_RD_S3) g1_pos <= g1_next;
      if (state == ST_MUL_L) g2_pos <= g2_next;
      if (state == ST_WR_L1 && low_phase) low_hold <= sum_val;
      if (done_go) begin
        main_wp   <= main_wp + 2'd2;
        short_wp  <= short_wp + 2'd2;
        high_wp   <= high_wp + 1'b1;
        high_rp   <= high_rp + 2'd2;
        low_wp    <= low_wp + (low_phase ? 2'd1 : 2'd2);
        low_rp    <= low_rp + 1'b1;
        low_phase <= !low_phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      mix_out       <= fb_sum(tap1, PROD_W'(x) <<< 15);
      short_out     <= r_short;
      chained_out   <= r_chained;
      low_out       <= r_low;
      high_out      <= high_q;
      grain_one_out <= r_g1;
      grain_two_out <= r_g2;
    end
  end

  `MTFD_ASSERT_NOW(a_clear_idle, clearing, state == ST_IDLE, "sequencer ran during clearing")
  `MTFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(mix_out) && $stable(high_out), "stalled word changed")
  `MTFD_ASSERT_NEXT(a_idle_wait, state == ST_IDLE && !in_full, state == ST_IDLE,
                    "sequencer started with no word")
  `MTFD_ASSERT_NEXT(a_done_wait, state == ST_DONE && out_valid && out_stall,
                    state == ST_DONE, "result dropped while output stalled")

endmodule
